[sv/etc1bd_pkg.sv]
// shared types, constants and helpers for the etc1 block decoder
// used by etc1bd_texel and etc1_block_decoder_unit
package etc1bd_pkg;

   localparam int BLOCK_W = 64;
   localparam int PIX_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int MOD_W   = 9;   // signed modifier, magnitude up to 183
   localparam int COLS    = 4;

   localparam logic [1:0] ROW_FIRST = 2'd0;
   localparam logic [1:0] ROW_LAST  = 2'd3;

   // control bits of the block word
   localparam int BIT_DIFF = 33;
   localparam int BIT_FLIP = 32;

   typedef struct packed {
      logic [PIX_W-1:0]        color;
      logic signed [MOD_W-1:0] modv;
   } texel_in_type;

   // modifier table magnitude: row picked by table index, column by selector lsb
   function automatic logic [CHAN_W-1:0] mod_mag(input logic [2:0] tidx, input logic lsb);
      logic [CHAN_W-1:0] a;
      logic [CHAN_W-1:0] b;
      begin
         case (tidx)
            3'd0: begin a = 8'd2;  b = 8'd8;   end
            3'd1: begin a = 8'd5;  b = 8'd17;  end
            3'd2: begin a = 8'd9;  b = 8'd29;  end
            3'd3: begin a = 8'd13; b = 8'd42;  end
            3'd4: begin a = 8'd18; b = 8'd60;  end
            3'd5: begin a = 8'd24; b = 8'd80;  end
            3'd6: begin a = 8'd33; b = 8'd106; end
            3'd7: begin a = 8'd47; b = 8'd183; end
            default: begin a = 8'd0; b = 8'd0; end
         endcase
         return lsb ? b : a;
      end
   endfunction

   function automatic logic [CHAN_W-1:0] expand4(input logic [3:0] v);
      return {v, v};
   endfunction

   function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

endpackage

[sv/etc1_block_decoder_unit.sv]
// etc1 block decoder: an accepted block is held in stage a, and each row passes the stage b and
// stage c registers to rsp_; rows 1..3 follow at one row word per cycle while rsp_tready does not stall.
// the row sequencer issues one row a cycle unless stage b is full and cannot move on;
// the next block is taken in the cycle the last row of the current one is issued.
// synchronous active-high reset clears the valid bits and the row counter; data is not reset.
// depends on etc1bd_pkg and etc1bd_texel
module etc1_block_decoder_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // block_word
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata,   // pixel_0, pixel_1, pixel_2, pixel_3
   output logic [1:0]    rsp_tuser,   // row_index
   output logic          rsp_tlast    // last_row
);

   // stage a: held block and row sequencer
   logic [etc1bd_pkg::BLOCK_W-1:0] blk_ff;
   logic                           blk_vld_ff, blk_vld_in;
   logic [1:0]                     row_ff, row_in;
   // stage b: per-texel base color and modifier
   etc1bd_pkg::texel_in_type       b_tex_ff [etc1bd_pkg::COLS];
   etc1bd_pkg::texel_in_type       b_tex_in [etc1bd_pkg::COLS];
   logic [1:0]                     b_row_ff;
   logic                           b_vld_ff, b_vld_in;
   // stage c: output word
   logic [etc1bd_pkg::PIX_W-1:0]   c_pix [etc1bd_pkg::COLS];
   logic [95:0]                    c_data_ff;
   logic [1:0]                     c_row_ff;
   logic                           c_vld_ff, c_vld_in;

   logic c_ready, b_ready, issue, req_acc;
   logic [7:0] col0 [3];
   logic [7:0] col1 [3];

   assign c_ready    = !c_vld_ff || rsp_tready;
   assign b_ready    = !b_vld_ff || c_ready;
   assign issue      = blk_vld_ff && b_ready;
   assign req_tready = !blk_vld_ff || (issue && row_ff == etc1bd_pkg::ROW_LAST);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      blk_vld_in = blk_vld_ff;
      row_in     = row_ff;
      if (issue) begin
         row_in = row_ff + 2'd1;
         if (row_ff == etc1bd_pkg::ROW_LAST) begin
            blk_vld_in = 1'b0;
         end
      end
      if (req_acc) begin
         blk_vld_in = 1'b1;
         row_in     = etc1bd_pkg::ROW_FIRST;
      end
   end

   // base colors of both halves; channel c = 0 is red
   always_comb begin
      logic [4:0] base5;
      logic [2:0] dlt;
      logic [4:0] sum5;
      for (int c = 0; c < 3; c++) begin
         base5 = blk_ff[63-8*c -: 5];
         dlt   = blk_ff[58-8*c -: 3];
         sum5  = base5 + {{2{dlt[2]}}, dlt};   // wraps modulo 32
         if (blk_ff[etc1bd_pkg::BIT_DIFF]) begin
            col0[c] = etc1bd_pkg::expand5(base5);
            col1[c] = etc1bd_pkg::expand5(sum5);
         end else begin
            col0[c] = etc1bd_pkg::expand4(blk_ff[63-8*c -: 4]);
            col1[c] = etc1bd_pkg::expand4(blk_ff[59-8*c -: 4]);
         end
      end
   end

   always_comb begin
      logic [3:0]                    k;
      logic                          half;
      logic [2:0]                    tidx;
      logic [etc1bd_pkg::CHAN_W-1:0] mag;
      for (int x = 0; x < etc1bd_pkg::COLS; x++) begin
         k    = {2'(x), row_ff};   // selector bit y + 4x
         half = blk_ff[etc1bd_pkg::BIT_FLIP] ? row_ff[1] : k[3];
         tidx = half ? blk_ff[36:34] : blk_ff[39:37];
         mag  = etc1bd_pkg::mod_mag(tidx, blk_ff[k]);
         b_tex_in[x].modv  = blk_ff[5'd16 + 5'(k)] ? -$signed({1'b0, mag})
                                                    : $signed({1'b0, mag});
         b_tex_in[x].color = half ? {col1[0], col1[1], col1[2]}
                                  : {col0[0], col0[1], col0[2]};
      end
   end

   assign b_vld_in = issue || (b_vld_ff && !c_ready);
   assign c_vld_in = (b_vld_ff && c_ready) || (c_vld_ff && !rsp_tready);

   for (genvar x = 0; x < etc1bd_pkg::COLS; x++) begin : g_texel
      etc1bd_texel u_texel (
         .texel_in (b_tex_ff[x]),
         .pixel    (c_pix[x])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_vld_ff <= 1'b0;
         row_ff     <= etc1bd_pkg::ROW_FIRST;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
      end else begin
         blk_vld_ff <= blk_vld_in;
         row_ff     <= row_in;
         b_vld_ff   <= b_vld_in;
         c_vld_ff   <= c_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         blk_ff <= req_tdata;
      end
      if (issue) begin
         b_tex_ff <= b_tex_in;
         b_row_ff <= row_ff;
      end
      if (b_vld_ff && c_ready) begin
         c_data_ff <= {c_pix[3], c_pix[2], c_pix[1], c_pix[0]};
         c_row_ff  <= b_row_ff;
      end
   end

   assign rsp_tvalid = c_vld_ff;
   assign rsp_tdata  = c_data_ff;
   assign rsp_tuser  = c_row_ff;
   assign rsp_tlast  = (c_row_ff == etc1bd_pkg::ROW_LAST);

`ifndef SYNTHESIS
   // a new block only replaces a held one when its last row goes out
   a_accept_on_last: assert property (@(posedge clock) disable iff (reset)
      (req_acc && blk_vld_ff) |-> (row_ff == etc1bd_pkg::ROW_LAST && issue))
      else $error("block overwritten before its last row was issued");

   // a stalled row word in stage b is kept
   a_b_hold: assert property (@(posedge clock) disable iff (reset)
      (b_vld_ff && !c_ready) |=> (b_vld_ff && $stable(b_row_ff)))
      else $error("stage b word lost under stall");

   // rows leave stage a in order
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (issue && !req_acc) |=> (row_ff == $past(row_ff) + 2'd1))
      else $error("row sequencer skipped a row");
`endif

endmodule

[sv/etc1bd_texel.sv]
// one texel: adds the signed modifier to each channel of the base color and clamps to 0..255
// depends on etc1bd_pkg
module etc1bd_texel (
   input  etc1bd_pkg::texel_in_type     texel_in,
   output logic [etc1bd_pkg::PIX_W-1:0] pixel
);

   always_comb begin
      logic signed [9:0] sum;
      for (int c = 0; c < 3; c++) begin
         sum = $signed({2'b00, texel_in.color[c*8 +: 8]})
             + $signed({texel_in.modv[etc1bd_pkg::MOD_W-1], texel_in.modv});
         if (sum < 10'sd0) begin
            pixel[c*8 +: 8] = 8'd0;
         end else if (sum > 10'sd255) begin
            pixel[c*8 +: 8] = 8'd255;
         end else begin
            pixel[c*8 +: 8] = sum[7:0];
         end
      end
   end

endmodule

[tb/sv/etc1_block_decoder_unit_tb.sv]
// self-checking testbench for etc1_block_decoder_unit: decodes every block sent
// in its own tile predictor and compares each row word; needs etc1bd_pkg and the rtl
`timescale 1ns / 1ps

module etc1_block_decoder_unit_tb;

   localparam int TOTAL_RANDOM = 500;
   localparam int HOLD_CYCLES  = 250;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE       = 12;

   typedef struct packed {
      logic [etc1bd_pkg::COLS-1:0][etc1bd_pkg::PIX_W-1:0] pixel;
      logic [1:0]                                         row;
      logic                                               last;
   } tile_row_type;

   typedef struct {
      logic [etc1bd_pkg::BLOCK_W-1:0] blk;
      bit                             drain;   // wait for every row of earlier blocks first
   } block_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;   // block_word
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;        // pixel_0, pixel_1, pixel_2, pixel_3
   logic [1:0]   rsp_tuser;        // row_index
   logic         rsp_tlast;        // last_row

   block_item_type block_queue[$];
   tile_row_type   row_expect[$];
   int           total_blocks = 0;
   int           blocks_sent = 0;
   int           rows_predicted = 0;
   int           rows_checked = 0;
   int           mismatches = 0;
   int           gap_left = 0;
   int           stall_left = 0;
   int           hold_left = 0;
   bit           hold_done = 1'b0;
   int           quiet_cycles = 0;

   // modifier magnitudes per table index, selector lsb picks the column
   int modifier_mag [8][2] = '{'{2, 8}, '{5, 17}, '{9, 29}, '{13, 42},
                               '{18, 60}, '{24, 80}, '{33, 106}, '{47, 183}};

   etc1_block_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic tile_row_type decode_row(input logic [63:0] blk, input int y);
      logic [31:0] hi;
      logic [31:0] lo;
      logic [7:0]  base_col [2][3];
      logic [4:0]  b5;
      logic [4:0]  s5;
      logic [2:0]  tsel;
      int          sh;
      int          half;
      int          k;
      int          m;
      int          v;
      tile_row_type r;
      hi = blk[63:32];
      lo = blk[31:0];
      for (int c = 0; c < 3; c++) begin
         sh = 24 - 8 * c;
         if (hi[1]) begin
            // differential: 5-bit base plus signed 3-bit delta, sum wraps mod 32
            b5 = hi[sh+3 +: 5];
            s5 = b5 + {{2{hi[sh+2]}}, hi[sh +: 3]};
            base_col[0][c] = {b5, b5[4:2]};
            base_col[1][c] = {s5, s5[4:2]};
         end else begin
            base_col[0][c] = {2{hi[sh+4 +: 4]}};
            base_col[1][c] = {2{hi[sh +: 4]}};
         end
      end
      for (int x = 0; x < 4; x++) begin
         half = hi[0] ? y / 2 : x / 2;
         k = y + 4 * x;
         tsel = half ? hi[4:2] : hi[7:5];
         m = modifier_mag[tsel][lo[k]];
         if (lo[k+16])
            m = -m;
         for (int c = 0; c < 3; c++) begin
            v = int'(base_col[half][c]) + m;
            if (v < 0)
               v = 0;
            else if (v > 255)
               v = 255;
            r.pixel[x][23-8*c -: 8] = v[7:0];
         end
      end
      r.row = y[1:0];
      r.last = (y == 3);
      return r;
   endfunction

   // colors (r,g,b bytes), table indices, mode bits, then the selector planes
   function automatic logic [63:0] pack_block(input logic [23:0] colors,
                                              input logic [2:0] t0, input logic [2:0] t1,
                                              input logic diff, input logic flip,
                                              input logic [31:0] sel);
      return {colors, t0, t1, diff, flip, sel};
   endfunction

   task automatic queue_block(input logic [63:0] blk, input bit drain);
      block_item_type item;
      item.blk = blk;
      item.drain = drain;
      block_queue.push_back(item);
   endtask

   // stimulus and end of run
   initial begin
      logic [63:0] blk;
      logic [7:0]  corner_bytes [4];
      int          drain_at;
      corner_bytes = '{8'h00, 8'hFF, 8'hFB, 8'h04};
      queue_block(64'h0, 1'b0);
      queue_block({64{1'b1}}, 1'b0);
      queue_block(pack_block(24'hF0F0F0, 3'd7, 3'd7, 1'b0, 1'b0, 32'hFFFF_0000), 1'b0);
      queue_block(pack_block(24'hF0F0F0, 3'd7, 3'd7, 1'b0, 1'b1, 32'h0000_FFFF), 1'b0);
      queue_block(pack_block(24'h0F0F0F, 3'd7, 3'd0, 1'b0, 1'b0, 32'hFFFF_FFFF), 1'b0);
      // differential wrap both ways: base 31 + 3, base 0 - 4, base 31 - 1, base 0 + 3
      queue_block(pack_block(24'hFBFBFB, 3'd6, 3'd7, 1'b1, 1'b0, 32'h0000_FFFF), 1'b0);
      queue_block(pack_block(24'h040404, 3'd7, 3'd6, 1'b1, 1'b1, 32'hFFFF_FFFF), 1'b0);
      queue_block(pack_block(24'hFFFFFF, 3'd3, 3'd4, 1'b1, 1'b0, 32'hAAAA_5555), 1'b0);
      queue_block(pack_block(24'h030303, 3'd1, 3'd2, 1'b1, 1'b1, 32'h5555_AAAA), 1'b0);
      for (int i = 0; i < 8; i++)
         queue_block(pack_block(24'($urandom), i[2:0], 3'd7 - i[2:0], i[0], i[1], $urandom),
                     i == 4);
      queue_block(pack_block(24'hFB04FF, 3'd5, 3'd2, 1'b1, 1'b0, 32'h0F0F_F0F0), 1'b0);
      queue_block(pack_block(24'h0FF00F, 3'd0, 3'd7, 1'b0, 1'b1, 32'h3C3C_C3C3), 1'b0);

      drain_at = $urandom_range(150, 350);
      for (int i = 0; i < TOTAL_RANDOM; i++) begin
         blk = {$urandom, $urandom};
         // a third of the blocks get saturating or wrap-prone color bytes
         if ($urandom_range(0, 2) == 0)
            for (int c = 0; c < 3; c++)
               blk[63-8*c -: 8] = corner_bytes[$urandom_range(0, 3)];
         queue_block(blk, i == drain_at);
      end
      total_blocks = block_queue.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (block_queue.size() != 0 || req_tvalid || row_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("etc1_block_decoder_unit_tb: clean");
      else
         $display("etc1_block_decoder_unit_tb: errors");
      $finish;
   end

   // block driver
   always @(posedge clock) begin
      logic offer;
      bit   tail;
      int   pending;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         pending = rows_predicted - rows_checked;
         tail = (blocks_sent + 60 >= total_blocks);
         if (req_tvalid && req_tready) begin
            for (int y = 0; y < 4; y++)
               row_expect.push_back(decode_row(req_tdata, y));
            rows_predicted <= rows_predicted + 4;
            blocks_sent <= blocks_sent + 1;
            pending = pending + 4;
            offer = 1'b0;
            if (!tail && (blocks_sent / 50) % 3 != 2 && $urandom_range(0, 4) == 0)
               gap_left = $urandom_range(1, 15);
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (block_queue.size() != 0 && !(block_queue[0].drain && pending != 0)) begin
               req_tdata <= block_queue[0].blk;
               void'(block_queue.pop_front());
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
      end
   end

   // row word monitor and checker
   always @(posedge clock) begin
      tile_row_type want;
      logic         ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rows_checked <= rows_checked + 1;
            if (row_expect.size() == 0) begin
               $display("%0t unexpected row word: expected none, got row %0d data %h last %b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = row_expect.pop_front();
               for (int x = 0; x < etc1bd_pkg::COLS; x++)
                  if (rsp_tdata[24*x +: 24] !== want.pixel[x]) begin
                     $display("%0t row %0d pixel_%0d: expected %h, got %h",
                              $time, want.row, x, want.pixel[x], rsp_tdata[24*x +: 24]);
                     mismatches++;
                  end
               if (rsp_tuser !== want.row) begin
                  $display("%0t row_index: expected %0d, got %0d", $time, want.row, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t row %0d last_row: expected %b, got %b",
                           $time, want.row, want.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
         // one long hold-off while the sender keeps offering, to back up the block
         if (!hold_done && blocks_sent == 120) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready = 1'b0;
         end else if (blocks_sent + 60 < total_blocks && (rows_checked / 200) % 3 != 1
                      && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            ready = 1'b0;
         end else begin
            ready = 1'b1;
         end
         rsp_tready <= ready;
      end
   end

   // watchdog on cycles where neither side moves a word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t timeout: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("etc1_block_decoder_unit_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
